// ===== rtl/swhd_pkg.sv =====
`default_nettype none
package swhd_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int PHASE_BITS   = 16;

  localparam int LOG_SE = $clog2(SINE_ENTRIES);
  localparam int QTR    = SINE_ENTRIES / 4;
  localparam int QBITS  = $clog2(QTR);

  localparam int NUM_W = 32;
  localparam int DEN_W = 20;

  localparam int FRAC_LAT = NUM_W + 2 + PHASE_BITS;
  localparam int PIPE_LAT = FRAC_LAT + 4;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [2:0] {
    REG_WAVE_SIZE    = 3'd0,
    REG_TIDE_RATE    = 3'd1,
    REG_TIDE_SIZE    = 3'd2,
    REG_BASE_HEIGHT  = 3'd3,
    REG_WAVE_ALONG_Z = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_z;
    logic [31:0]        tick;
  } item_t;

  typedef struct packed {
    logic signed [32:0] height;
    logic               tide_active;
  } result_t;

  typedef logic [QTR-1:0][14:0] qtab_t;

  function automatic logic [14:0] sine_mag(int h);
    logic [63:0]        m;
    logic [63:0]        theta;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic [63:0]        p;
    logic signed [63:0] sum;
    m     = 64'(2 * h);
    theta = (m * TWO_PI_Q30) / (2 * SINE_ENTRIES);
    th2   = (theta * theta) >> 30;
    term  = theta;
    sum   = $signed(theta);
    for (int k = 1; k <= 7; k++) begin
      p = (term * th2) >> 30;
      case (k)
        1: term = p / 6;
        2: term = p / 20;
        3: term = p / 42;
        4: term = p / 72;
        5: term = p / 110;
        6: term = p / 156;
        default: term = p / 210;
      endcase
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return sum[14:0];
  endfunction

  function automatic qtab_t sine_table();
    qtab_t tab;
    for (int i = 0; i < QTR; i++) begin
      tab[i] = sine_mag(i);
    end
    return tab;
  endfunction

  localparam qtab_t       SINE_QTR  = sine_table();
  localparam logic [14:0] SINE_PEAK = sine_mag(QTR);

endpackage
`default_nettype wire

// ===== rtl/swhd_frac.sv =====
`default_nettype none
module swhd_frac
  import swhd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire logic [NUM_W-1:0]      num,
  input  wire logic                  neg,
  input  wire logic [DEN_W-1:0]      den,
  output logic      [PHASE_BITS-1:0] frac
);

  logic [DEN_W-1:0]      rem_m [0:NUM_W];
  logic [NUM_W-1:0]      num_m [0:NUM_W-1];
  logic                  neg_m [0:NUM_W];
  logic [DEN_W-1:0]      rem_f [0:PHASE_BITS-1];
  logic [PHASE_BITS-1:0] q_f   [0:PHASE_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_m[0] <= '0;
      num_m[0] <= num;
      neg_m[0] <= neg;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_mod
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_m[i], num_m[i][NUM_W-1-i]};
    assign ge = t >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_m[i+1] <= ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
        neg_m[i+1] <= neg_m[i];
      end
    end
    if (i < NUM_W - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (adv) begin
          num_m[i+1] <= num_m[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_f[0] <= (neg_m[NUM_W] && rem_m[NUM_W] != '0) ? den - rem_m[NUM_W] : rem_m[NUM_W];
      q_f[0]   <= '0;
    end
  end

  for (genvar j = 0; j < PHASE_BITS; j++) begin : g_div
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_f[j], 1'b0};
    assign ge = t >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (adv) begin
        q_f[j+1] <= {q_f[j][PHASE_BITS-2:0], ge};
      end
    end
    if (j < PHASE_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_f[j+1] <= ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
        end
      end
    end
  end

  assign frac = (den == '0) ? '0 : q_f[PHASE_BITS];

endmodule
`default_nettype wire

// ===== rtl/sine_wave_height_displacement.sv =====
// Tidal water height per vertex. One item (coord_x, coord_z, tick) enters per cycle unless
// the result side stalls; the depth is set by the two long-division chains, one bit per
// stage: an input register, 32 remainder steps, one floor-modulo fix and 16 fraction steps,
// followed by phase fold, sine lookup, multiply and output stages. A stall on the result side
// freezes the whole pipeline. Registers at byte address 4*i: wave_size, tide_rate, tide_size,
// base_height, wave_along_z; write them only while no item is in flight.
`default_nettype none
module sine_wave_height_displacement
  import swhd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result
);

  logic [15:0] wave_size;
  logic [19:0] tide_rate;
  logic [15:0] tide_size;
  logic [23:0] base_height;
  logic        wave_along_z;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_size    <= 16'd1;
      tide_rate    <= '0;
      tide_size    <= '0;
      base_height  <= '0;
      wave_along_z <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_WAVE_SIZE:    wave_size    <= pwdata[15:0];
        REG_TIDE_RATE:    tide_rate    <= pwdata[19:0];
        REG_TIDE_SIZE:    tide_size    <= pwdata[15:0];
        REG_BASE_HEIGHT:  base_height  <= pwdata[23:0];
        REG_WAVE_ALONG_Z: wave_along_z <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_WAVE_SIZE:    prdata = {16'd0, wave_size};
      REG_TIDE_RATE:    prdata = {12'd0, tide_rate};
      REG_TIDE_SIZE:    prdata = {16'd0, tide_size};
      REG_BASE_HEIGHT:  prdata = {8'd0, base_height};
      REG_WAVE_ALONG_Z: prdata = {31'd0, wave_along_z};
      default:          prdata = '0;
    endcase
  end

  logic                adv;
  logic [PIPE_LAT-1:0] v;

  assign adv          = !v[PIPE_LAT-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = v[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[PIPE_LAT-2:0], item_valid};
    end
  end

  logic signed [23:0]    k;
  logic [23:0]           kmag;
  logic [PHASE_BITS-1:0] fb;
  logic [PHASE_BITS-1:0] ft;

  assign k    = wave_along_z ? item.coord_z : item.coord_x;
  assign kmag = k[23] ? 24'(-k) : k;

  swhd_frac u_wave (
    .clk  (clk),
    .adv  (adv),
    .num  ({8'd0, kmag}),
    .neg  (k[23]),
    .den  ({2'b00, wave_size, 2'b00}),
    .frac (fb)
  );

  swhd_frac u_tide (
    .clk  (clk),
    .adv  (adv),
    .num  (item.tick),
    .neg  (1'b0),
    .den  (tide_rate),
    .frac (ft)
  );

  logic [PHASE_BITS-1:0]        phase;
  logic [PHASE_BITS+LOG_SE-1:0] phase_ext;
  logic [LOG_SE-1:0]            idx;
  logic [QBITS:0]               h_raw;
  logic [QBITS:0]               h_fold;

  assign phase     = fb + ft;
  assign phase_ext = {{LOG_SE{1'b0}}, phase} << LOG_SE;
  assign idx       = LOG_SE'(phase_ext >> PHASE_BITS);
  assign h_raw     = idx[LOG_SE-2:0];
  assign h_fold    = (h_raw > (QBITS+1)'(QTR)) ? (QBITS+1)'(2 * QTR) - h_raw : h_raw;

  logic               neg_a;
  logic [QBITS:0]     h_a;
  logic signed [15:0] sine_b;
  logic signed [32:0] prod_c;
  logic [14:0]        mag;
  logic signed [32:0] base_s;

  assign mag    = (h_a == (QBITS+1)'(QTR)) ? SINE_PEAK : SINE_QTR[h_a[QBITS-1:0]];
  assign base_s = {base_height[23], base_height, 8'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_a  <= idx[LOG_SE-1];
      h_a    <= h_fold;
      sine_b <= neg_a ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      prod_c <= $signed({1'b0, tide_size}) * sine_b;
      if (tide_size != '0 && tide_rate != '0) begin
        result.height      <= base_s - (prod_c >>> 7);
        result.tide_active <= 1'b1;
      end else begin
        result.height      <= base_s;
        result.tide_active <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input held off without output stall");

  a_active_matches_cfg: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.tide_active == (tide_size != '0 && tide_rate != '0))
    else $error("tide_active disagrees with configuration");

  a_base_when_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tide_active |-> result.height == base_s)
    else $error("height differs from base with tides off");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !v[PIPE_LAT-2] |=> !result_valid)
    else $error("result repeated after drain");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/sine_wave_height_displacement_tb.sv =====
`default_nettype none
module sine_wave_height_displacement_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swhd_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;

  logic [15:0]        wave_size_q = 16'd1;
  logic [19:0]        tide_rate_q = '0;
  logic [15:0]        tide_size_q = '0;
  logic signed [23:0] base_height_q = '0;
  logic               along_z_q = 1'b0;

  result_t heights_due[$];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      errors = 0;
  int      checked = 0;
  longint  cycles = 0;

  sine_wave_height_displacement i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sine_q15(u64_t idx);
    u64_t   m;
    u64_t   theta;
    u64_t   th2;
    u64_t   term;
    longint sum;
    bit     neg;
    neg = 1'b0;
    m = (idx % SINE_ENTRIES) * 2;
    if (m >= SINE_ENTRIES) begin
      neg = 1'b1;
      m = m - SINE_ENTRIES;
    end
    if (2 * m > SINE_ENTRIES) m = SINE_ENTRIES - m;
    theta = (m * 64'd6746518852) / (2 * SINE_ENTRIES);
    th2 = (theta * theta) >> 30;
    term = theta;
    sum = longint'(theta);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * th2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return neg ? -sum : sum;
  endfunction

  function automatic result_t water_height(item_t it);
    longint  base;
    longint  h;
    longint  k;
    longint  w;
    longint  r;
    longint  prod;
    u64_t    fb;
    u64_t    ft;
    u64_t    t;
    u64_t    phase;
    u64_t    idx;
    result_t res;
    base = longint'(base_height_q) * 256;
    h = base;
    res.tide_active = 1'b0;
    if (tide_size_q != 0 && tide_rate_q != 0) begin
      k = along_z_q ? longint'(it.coord_z) : longint'(it.coord_x);
      w = longint'(wave_size_q) <<< 2;
      fb = 0;
      if (w != 0) begin
        r = k % w;
        if (r < 0) r = r + w;
        fb = u64_t'(r <<< PHASE_BITS) / u64_t'(w);
      end
      t = u64_t'(it.tick) % u64_t'(tide_rate_q);
      ft = (t << PHASE_BITS) / u64_t'(tide_rate_q);
      phase = (fb + ft) & ((64'd1 << PHASE_BITS) - 1);
      idx = (phase * SINE_ENTRIES) >> PHASE_BITS;
      prod = longint'(tide_size_q) * sine_q15(idx);
      h = base - (prod >>> 7);
      res.tide_active = 1'b1;
    end
    res.height = h[32:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_valid && result_ready) begin
      checked++;
      if (heights_due.size() == 0) begin
        $error("unexpected item: height %0d", result.height);
        errors++;
      end else begin
        want = heights_due.pop_front();
        if (result.height !== want.height) begin
          $error("height: expected %0d, got %0d", want.height, result.height);
          errors++;
        end
        if (result.tide_active !== want.tide_active) begin
          $error("tide_active: expected %0b, got %0b", want.tide_active, result.tide_active);
          errors++;
        end
      end
    end
  end

  task automatic send_item(item_t it);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    heights_due.push_back(water_height(it));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WAVE_SIZE:    wave_size_q = val[15:0];
      REG_TIDE_RATE:    tide_rate_q = val[19:0];
      REG_TIDE_SIZE:    tide_size_q = val[15:0];
      REG_BASE_HEIGHT:  base_height_q = val[23:0];
      REG_WAVE_ALONG_Z: along_z_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_tide(logic [31:0] ws, logic [31:0] rate, logic [31:0] ts,
                          logic [31:0] bh, logic [31:0] az);
    reg_write(REG_WAVE_SIZE, ws);
    reg_write(REG_TIDE_RATE, rate);
    reg_write(REG_TIDE_SIZE, ts);
    reg_write(REG_BASE_HEIGHT, bh);
    reg_write(REG_WAVE_ALONG_Z, az);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.coord_x = 24'($urandom);
    it.coord_z = 24'($urandom);
    it.tick = $urandom;
    case ($urandom_range(7))
      0: it.coord_x = 24'sh800000;
      1: it.coord_x = 24'sh7fffff;
      2: it.coord_z = 24'sh800000;
      3: it.coord_z = 24'sh7fffff;
      4: it.tick = 32'hffffffff;
      5: it.tick = 32'($urandom_range(4095));
      default: ;
    endcase
    return it;
  endfunction

  function automatic item_t make_item(logic [23:0] x, logic [23:0] z, logic [31:0] t);
    item_t it;
    it.coord_x = x;
    it.coord_z = z;
    it.tick = t;
    return it;
  endfunction

  task automatic test_tides_off();
    send_item(make_item(24'h800000, 24'h7fffff, 32'hffffffff));
    send_item(make_item(24'h7fffff, 24'h800000, 32'h0));
    drain();
    set_tide(1, 0, 65535, 32'h00800000, 0);
    send_item(rand_item());
    drain();
    set_tide(1, 1048575, 0, 32'h007fffff, 1);
    send_item(rand_item());
    drain();
  endtask

  task automatic test_extremes();
    set_tide(65535, 1048575, 65535, 32'h00800000, 0);
    send_item(make_item(24'h800000, 24'h0, 32'hffffffff));
    send_item(make_item(24'h7fffff, 24'h0, 32'h0));
    send_item(make_item(24'hffffff, 24'h0, 32'd1048574));
    drain();
    set_tide(1, 1, 65535, 32'h007fffff, 1);
    for (int i = 0; i < 4; i++) send_item(make_item(24'h0, 24'(i - 2), 32'(i)));
    send_item(make_item(24'h0, 24'h800000, 32'hffffffff));
    drain();
    set_tide(1, 4, 65535, 32'h0, 0);
    for (int i = 0; i < 8; i++) send_item(make_item(24'(i), 24'h0, 32'(i)));
    drain();
    set_tide(0, 1000, 1234, 32'hfff000, 0);
    send_item(make_item(24'h123456, 24'h0, 32'd250));
    send_item(make_item(24'h800000, 24'h0, 32'd750));
    drain();
    for (int i = REG_WAVE_ALONG_Z + 1; i < 8; i++) reg_write(i, $urandom);
    send_item(rand_item());
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        drain();
        set_tide(($urandom_range(9) == 0) ? 0 : ($urandom_range(3) == 0 ?
                   $urandom_range(1, 8) : $urandom),
                 ($urandom_range(9) == 0) ? 0 : ($urandom_range(3) == 0 ?
                   $urandom_range(1, 64) : $urandom),
                 ($urandom_range(9) == 0) ? 0 : $urandom,
                 $urandom, $urandom);
      end
      send_item(rand_item());
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tides_off();
    test_extremes();
    test_random(600, 0, 0);
    test_random(400, 88, 0);
    test_random(400, 0, 88);
    test_random(400, 6, 6);
    $display("Checked %0d heights: tides off, register extremes, zero wave size,", checked);
    $display("unused register writes and random vertices under four handshake patterns.");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
